// ===== rtl/core/qsu_pkg.sv =====
// ============================================================================
// qsu_pkg
// Shared types, codes and character helpers of the quoted string unescaper.
// ============================================================================
package qsu_pkg;

	// Parse phases.
	localparam logic [1:0] PH_IDLE = 2'd0;  // expect opening quote
	localparam logic [1:0] PH_STR  = 2'd1;  // inside the string
	localparam logic [1:0] PH_ESC  = 2'd2;  // after a backslash
	localparam logic [1:0] PH_HEX1 = 2'd3;  // after one hex digit

	// Status codes of a result.
	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_OK    = 2'd1;
	localparam logic [1:0] ST_PAUSE = 2'd2;
	localparam logic [1:0] ST_ERR   = 2'd3;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEX_ESCAPES  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTINUATION = 1'd1;

	// Characters of interest.
	localparam logic [7:0] CH_EOB    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] LOWER_OFS = 8'd87;  // 'a' - 10
	localparam logic [7:0] UPPER_OFS = 8'd55;  // 'A' - 10

	// Default depth of the result queue.
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		res_t       res;
		logic [1:0] phase;
	} str_t;

	// Everything one byte produces.
	typedef struct packed {
		logic       two;
		res_t       res0;
		res_t       res1;
		logic [1:0] phase;
		logic [3:0] hex_value;
	} dec_t;

	function automatic res_t mk_res(input logic has, input logic [7:0] b,
			input logic [1:0] st, input logic lst);
		res_t r;
		r.has_byte = has;
		r.out_byte = has ? b : 8'h00;
		r.status   = st;
		r.last     = lst;
		return r;
	endfunction

	function automatic hex_t hex_val(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'h0;
		if (c >= CH_0 && c <= CH_9) begin
			h.val = c[3:0];
		end else if (c >= CH_LA && c <= CH_LF) begin
			h.val = 4'(c - LOWER_OFS);
		end else if (c >= CH_UA && c <= CH_UF) begin
			h.val = 4'(c - UPPER_OFS);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	// A byte seen inside the string; always the final result of its byte.
	function automatic str_t in_string(input logic [7:0] c, input logic cont);
		str_t s;
		if (c == CH_EOB) begin
			s.res   = mk_res(1'b0, 8'h00, cont ? ST_PAUSE : ST_ERR, 1'b1);
			s.phase = cont ? PH_STR : PH_IDLE;
		end else if (c == CH_QUOTE) begin
			s.res   = mk_res(1'b0, 8'h00, ST_OK, 1'b1);
			s.phase = PH_IDLE;
		end else if (c == CH_BSLASH) begin
			s.res   = mk_res(1'b0, 8'h00, ST_RUN, 1'b1);
			s.phase = PH_ESC;
		end else begin
			s.res   = mk_res(1'b1, c, ST_RUN, 1'b1);
			s.phase = PH_STR;
		end
		return s;
	endfunction

endpackage

// ===== rtl/core/qsu_decode.sv =====
// ============================================================================
// qsu_decode
// Next-phase and result logic for one text byte.
// ============================================================================
module qsu_decode import qsu_pkg::*; (
	input  logic [7:0] ch,
	input  logic [1:0] phase,
	input  logic [3:0] hex_value,
	input  logic       hex_escapes,
	input  logic       continuation,
	output dec_t       dec
);

	hex_t h;
	str_t s;

	assign h = hex_val(ch);
	assign s = in_string(ch, continuation);

	always_comb begin
		dec.two       = 1'b0;
		dec.res0      = mk_res(1'b0, 8'h00, ST_RUN, 1'b1);
		dec.res1      = mk_res(1'b0, 8'h00, ST_RUN, 1'b1);
		dec.phase     = phase;
		dec.hex_value = hex_value;
		unique case (phase)
			PH_IDLE: begin
				if (ch == CH_QUOTE) begin
					dec.phase = PH_STR;
				end else begin
					dec.res0  = mk_res(1'b0, 8'h00, ST_ERR, 1'b1);
					dec.phase = PH_IDLE;
				end
			end
			PH_STR: begin
				dec.res0  = s.res;
				dec.phase = s.phase;
			end
			PH_ESC: begin
				if (ch == CH_BSLASH || ch == CH_QUOTE) begin
					dec.res0  = mk_res(1'b1, ch, ST_RUN, 1'b1);
					dec.phase = PH_STR;
				end else if (hex_escapes && h.ok) begin
					dec.hex_value = h.val;
					dec.phase     = PH_HEX1;
				end else begin
					dec.res0  = mk_res(1'b0, 8'h00, ST_ERR, 1'b1);
					dec.phase = PH_IDLE;
				end
			end
			PH_HEX1: begin
				dec.hex_value = 4'h0;
				if (h.ok) begin
					dec.res0  = mk_res(1'b1, {hex_value, h.val}, ST_RUN, 1'b1);
					dec.phase = PH_STR;
				end else begin
					// The lone digit becomes a byte, then this byte is handled
					// as ordinary string content.
					dec.two   = 1'b1;
					dec.res0  = mk_res(1'b1, {4'h0, hex_value}, ST_RUN, 1'b0);
					dec.res1  = s.res;
					dec.phase = s.phase;
				end
			end
			default: begin
				dec.phase = PH_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/qsu_out_queue.sv =====
// ============================================================================
// qsu_out_queue
// Small result queue that takes one or two results per beat and hands out one.
// ============================================================================
module qsu_out_queue import qsu_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_two,
	input  res_t entry0,
	input  res_t entry1,
	output logic room,
	output logic out_valid,
	input  logic out_stall,
	output res_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	res_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_next;
	logic             pop;
	logic [1:0]       push_n;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	assign wr_next   = wrap_inc(wr_q);
	assign pop       = out_valid && !out_stall;
	assign out_valid = (count_q != '0);
	assign head      = mem[rd_q];
	assign room      = (count_q <= CNT_W'(DEPTH - 2));
	assign push_n    = push ? (push_two ? 2'd2 : 2'd1) : 2'd0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= entry0;
			if (push_two) begin
				mem[wr_next] <= entry1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= push_two ? wrap_inc(wr_next) : wr_next;
			end
			if (pop) begin
				rd_q <= wrap_inc(rd_q);
			end
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue count above depth");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q <= CNT_W'(DEPTH - 2))
		else $error("result queue written without room for two results");

endmodule

// ===== rtl/core/quoted_string_unescaper.sv =====
// ============================================================================
// quoted_string_unescaper
// Parses a double-quoted string one text byte per beat and emits the
// unescaped content bytes together with a parse status.
// ============================================================================
//
//   Channel  Direction  Handshake              Payload
//   -------  ---------  ---------------------  ---------------------------------
//   in       sink       in_valid / in_stall    ch
//   out      source     out_valid / out_stall  has_byte, out_byte, status, last
//   cfg      sink       cfg_we                 cfg_index, cfg_data
//
// A byte is decoded in the cycle it is taken and its results land in the
// result queue at that edge, so they are registered before they are offered.
// One byte per cycle is sustained while in_stall is low; a byte that yields
// two results (a lone hex digit followed by a non-hex byte) takes two reads
// on the queue's single read port. in_stall rises when the queue lacks room
// for two results. Reset returns the parser to "expect opening quote" and
// clears both configuration registers; the queue comes out of reset empty.
//
module quoted_string_unescaper import qsu_pkg::*; #(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            ch,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  has_byte,
	output logic [7:0]            out_byte,
	output logic [1:0]            status,
	output logic                  last,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Parser state and configuration.
	logic [1:0] phase_q;
	logic [3:0] hex_value_q;
	logic       hex_escapes_q;
	logic       continuation_q;

	logic accept;
	logic room;
	dec_t dec;
	res_t head;

	assign in_stall = !room;
	assign accept   = in_valid && !in_stall;

	// The whole per-byte decision is one shallow block of logic on the
	// incoming byte and the current phase.
	qsu_decode u_decode (
		.ch           (ch),
		.phase        (phase_q),
		.hex_value    (hex_value_q),
		.hex_escapes  (hex_escapes_q),
		.continuation (continuation_q),
		.dec          (dec)
	);

	// Results wait here, so new bytes keep flowing while the consumer stalls, as long as the queue has room.
	qsu_out_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_two  (dec.two),
		.entry0    (dec.res0),
		.entry1    (dec.res1),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign has_byte = head.has_byte;
	assign out_byte = head.out_byte;
	assign status   = head.status;
	assign last     = head.last;

	// Parser state advances only on an accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hex_value_q <= 4'h0;
		end else if (accept) begin
			phase_q     <= dec.phase;
			hex_value_q <= dec.hex_value;
		end
	end

	// Configuration writes; they take effect from the next byte on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_escapes_q  <= 1'b0;
			continuation_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEX_ESCAPES:  hex_escapes_q  <= cfg_data[0];
				CFG_CONTINUATION: continuation_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A pending hex digit only lives while the parser waits for the second one.
	a_hex_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_HEX1 |-> hex_value_q == 4'h0)
		else $error("hex digit left pending outside the hex phase");

	// A missing opening quote keeps the parser waiting for one.
	a_idle_stays: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_IDLE && ch != CH_QUOTE |=> phase_q == PH_IDLE)
		else $error("parser left idle without an opening quote");

	// Hex escapes cannot start while they are disabled.
	a_hex_gated: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_ESC && !hex_escapes_q |=> phase_q != PH_HEX1)
		else $error("hex escape started while hex escapes are off");

endmodule
